[rtl/yay0_lz_decompressor_macros.svh]
// Assertion macros shared by the Yay0 LZ decompressor RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef YAY0_LZ_DECOMPRESSOR_MACROS_SVH
`define YAY0_LZ_DECOMPRESSOR_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define YL_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, disabled while reset is high.
`define YL_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define YL_ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define YL_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

[rtl/yay0lz_pkg.sv]
// Shared types and constants for the Yay0 LZ decompressor.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package yay0lz_pkg;

   localparam int WINDOW_BYTES     = 4096;
   localparam int WIN_AW           = $clog2(WINDOW_BYTES);
   localparam int PACKET_BYTES_DEF = 8;

   localparam int BYTE_W      = 8;
   localparam int PC_W        = 24;
   localparam int DIST_W      = 13;
   localparam int LEFT_W      = 9;
   localparam int CNT_W       = 3;
   localparam int COUNT_W     = 4;
   localparam int IN_TDATA_W  = 32;
   localparam int OUT_TDATA_W = 64;
   localparam int OUT_TUSER_W = 6;

   localparam int SHORT_BIAS = 2;
   localparam int LONG_BIAS  = 18;

   localparam logic FUNC_LITERAL = 1'b0;
   localparam logic FUNC_LINK    = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRIME,
      ST_RUN
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic run;
   } ctrl_cmd_type;

   typedef struct packed {
      logic skip;
      logic step;
      logic last;
   } dp_status_type;

endpackage

[rtl/yay0lz_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the history window of the decompressor.
`timescale 1ns / 1ps

module yay0lz_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/yay0lz_ctrl.sv]
// Command sequencer of the Yay0 LZ decompressor: accepts requests and runs
// the byte loop. Depends on yay0lz_pkg.
`timescale 1ns / 1ps

module yay0lz_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  yay0lz_pkg::dp_status_type status,
   output yay0lz_pkg::ctrl_cmd_type  cmd
);

   import yay0lz_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            // A request on a finished or empty stream is taken and dropped.
            if (req_tvalid && !status.skip) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (status.step && status.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid && !status.skip;
         end
         ST_PRIME: begin
         end
         ST_RUN: begin
            cmd.run = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

[rtl/yay0lz_dp.sv]
// Datapath of the Yay0 LZ decompressor: stream counters, history window,
// packet assembly and the result register. Depends on yay0lz_pkg, yay0lz_ram.
`timescale 1ns / 1ps
`include "yay0_lz_decompressor_macros.svh"

module yay0lz_dp #(
   parameter int PACKET_BYTES = yay0lz_pkg::PACKET_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [yay0lz_pkg::IN_TDATA_W-1:0]   req_tdata,
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [yay0lz_pkg::OUT_TDATA_W-1:0]  rsp_tdata,
   output logic                                rsp_tlast,
   output logic [yay0lz_pkg::OUT_TUSER_W-1:0]  rsp_tuser,
   input  logic                                csr_we,
   input  logic [yay0lz_pkg::PC_W-1:0]         csr_wdata,
   input  yay0lz_pkg::ctrl_cmd_type            cmd,
   output yay0lz_pkg::dp_status_type           status
);

   import yay0lz_pkg::*;

   localparam logic [COUNT_W-1:0] PKT_N = COUNT_W'(PACKET_BYTES);

   // Stream state.
   logic [PC_W-1:0] length_ff, length_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic            done_ff, done_in;

   // Current command.
   logic              func_ff, func_in;
   logic [BYTE_W-1:0] literal_ff, literal_in;
   logic              dist_one_ff, dist_one_in;
   logic              bad_ff, bad_in;
   logic              finished_ff, finished_in;
   logic [PC_W:0]     src_ff, src_in;
   logic [LEFT_W-1:0] left_ff, left_in;
   logic [BYTE_W-1:0] last_byte_ff, last_byte_in;
   logic [OUT_TDATA_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // Result register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OUT_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_done_ff, rsp_done_in;
   logic                   rsp_bad_ff, rsp_bad_in;

   // Decode of the incoming request.
   logic [BYTE_W-1:0] req_literal;
   logic [15:0]       req_code;
   logic [3:0]        req_nib;
   logic [BYTE_W-1:0] req_ext;
   logic [DIST_W-1:0] req_dist;
   logic [LEFT_W-1:0] req_total;
   logic [PC_W-1:0]   remaining;
   logic              req_fin;

   // Byte loop.
   logic [BYTE_W-1:0]      ram_rd_data;
   logic [BYTE_W-1:0]      cur_byte;
   logic [PC_W:0]          src_inc;
   logic [WIN_AW-1:0]      rd_addr;
   logic                   completes;
   logic                   out_free;
   logic                   step;
   logic                   flush;
   logic                   last_byte;
   logic [OUT_TDATA_W-1:0] packed_bytes;

   assign req_literal = req_tdata[7:0];
   assign req_code    = req_tdata[23:8];
   assign req_ext     = req_tdata[31:24];
   assign req_nib     = req_code[15:12];
   assign req_dist    = {1'b0, req_code[WIN_AW-1:0]} + DIST_W'(1);

   always_comb begin
      if (req_tuser == FUNC_LINK) begin
         if (req_nib != 4'd0) begin
            req_total = {5'b0, req_nib} + LEFT_W'(SHORT_BIAS);
         end else begin
            req_total = {1'b0, req_ext} + LEFT_W'(LONG_BIAS);
         end
      end else begin
         req_total = LEFT_W'(1);
      end
   end

   assign remaining = length_ff - pc_ff;
   assign req_fin   = {{(PC_W-LEFT_W){1'b0}}, req_total} >= remaining;

   // A source before the first byte of the stream shows up as a negative
   // source index and reads as zero. A distance of one reads the byte just
   // written, which the RAM cannot return yet, so it comes from a register.
   always_comb begin
      if (func_ff == FUNC_LINK) begin
         if (src_ff[PC_W]) begin
            cur_byte = '0;
         end else if (dist_one_ff) begin
            cur_byte = last_byte_ff;
         end else begin
            cur_byte = ram_rd_data;
         end
      end else begin
         cur_byte = literal_ff;
      end
   end

   assign last_byte    = (left_ff == LEFT_W'(1));
   assign completes    = (({1'b0, cnt_ff} + COUNT_W'(1)) == PKT_N) || last_byte;
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign step         = cmd.run && (!completes || out_free);
   assign flush        = step && completes;
   assign packed_bytes = acc_ff
                       | ({{(OUT_TDATA_W-BYTE_W){1'b0}}, cur_byte} << {cnt_ff, 3'b000});
   assign src_inc      = src_ff + (PC_W+1)'(1);
   assign rd_addr      = step ? src_inc[WIN_AW-1:0] : src_ff[WIN_AW-1:0];

   assign status.skip = done_ff || (pc_ff >= length_ff);
   assign status.step = step;
   assign status.last = last_byte;

   yay0lz_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (WINDOW_BYTES)
   ) u_history (
      .clock   (clock),
      .wr_en   (step),
      .wr_addr (pc_ff[WIN_AW-1:0]),
      .wr_data (cur_byte),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      length_in    = length_ff;
      pc_in        = pc_ff;
      done_in      = done_ff;
      func_in      = func_ff;
      literal_in   = literal_ff;
      dist_one_in  = dist_one_ff;
      bad_in       = bad_ff;
      finished_in  = finished_ff;
      src_in       = src_ff;
      left_in      = left_ff;
      last_byte_in = last_byte_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_bad_in   = rsp_bad_ff;

      if (cmd.load) begin
         func_in     = req_tuser;
         literal_in  = req_literal;
         dist_one_in = (req_code[WIN_AW-1:0] == '0);
         bad_in      = (req_tuser == FUNC_LINK)
                    && ({{(PC_W-DIST_W){1'b0}}, req_dist} > pc_ff);
         finished_in = req_fin;
         left_in     = req_fin ? remaining[LEFT_W-1:0] : req_total;
         src_in      = {1'b0, pc_ff} - {{(PC_W+1-DIST_W){1'b0}}, req_dist};
         acc_in      = '0;
         cnt_in      = '0;
      end

      if (step) begin
         pc_in        = pc_ff + PC_W'(1);
         src_in       = src_inc;
         left_in      = left_ff - LEFT_W'(1);
         last_byte_in = cur_byte;
         if (flush) begin
            acc_in       = '0;
            cnt_in       = '0;
            rsp_valid_in = 1'b1;
            rsp_data_in  = packed_bytes;
            rsp_count_in = {1'b0, cnt_ff} + COUNT_W'(1);
            rsp_last_in  = last_byte;
            rsp_done_in  = last_byte && finished_ff;
            rsp_bad_in   = bad_ff;
         end else begin
            acc_in = packed_bytes;
            cnt_in = cnt_ff + CNT_W'(1);
         end
         if (last_byte && finished_ff) begin
            done_in = 1'b1;
         end
      end

      if (csr_we) begin
         length_in = csr_wdata;
         pc_in     = '0;
         done_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         pc_ff        <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         length_ff    <= length_in;
         pc_ff        <= pc_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      literal_ff   <= literal_in;
      dist_one_ff  <= dist_one_in;
      bad_ff       <= bad_in;
      finished_ff  <= finished_in;
      src_ff       <= src_in;
      left_ff      <= left_in;
      last_byte_ff <= last_byte_in;
      acc_ff       <= acc_in;
      cnt_ff       <= cnt_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_bad_ff, rsp_done_ff, rsp_count_ff};

   `YL_ASSERT_IMPLIES(a_count_range, clock, reset, rsp_valid_ff,
      (rsp_count_ff != '0) && (rsp_count_ff <= PKT_N))
   `YL_ASSERT_IMPLIES(a_done_on_end, clock, reset, rsp_valid_ff && rsp_done_ff, rsp_last_ff)
   `YL_ASSERT_IMPLIES(a_pc_bounded, clock, reset, 1'b1, pc_ff <= length_ff)
   `YL_ASSERT_NEXT(a_done_set, clock, reset,
      step && last_byte && finished_ff && !csr_we, done_ff)

endmodule

[rtl/yay0_lz_decompressor.sv]
// Yay0 LZ decompressor back end. A request is accepted in ST_IDLE, ST_PRIME
// primes the history read, then ST_RUN emits one byte per cycle while no
// completed packet is held up by rsp_tready.
// A request on a finished or empty stream is dropped in its accept cycle.
// Synchronous active-high reset clears the length, byte count, done flag and
// response valid, and returns the controller to idle.
`timescale 1ns / 1ps

module yay0_lz_decompressor #(
   parameter int PACKET_BYTES = yay0lz_pkg::PACKET_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // literal_byte [7:0], link_code [23:8], length_extension [31:24]
   input  logic [yay0lz_pkg::IN_TDATA_W-1:0]   req_tdata,
   // func
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_bytes [63:0]
   output logic [yay0lz_pkg::OUT_TDATA_W-1:0]  rsp_tdata,
   // command_end
   output logic                                rsp_tlast,
   // byte_count [3:0], stream_done [4], bad_reference [5]
   output logic [yay0lz_pkg::OUT_TUSER_W-1:0]  rsp_tuser,
   input  logic                                csr_we,
   input  logic [yay0lz_pkg::PC_W-1:0]         csr_wdata
);

   import yay0lz_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   yay0lz_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   yay0lz_dp #(
      .PACKET_BYTES (PACKET_BYTES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

[test/yay0_lz_decompressor_tb.sv]
// Self-checking testbench for the Yay0 LZ decompressor back end.
// Drives literal and link requests, predicts every output packet in place and
// checks them in order. Depends on yay0lz_pkg and yay0_lz_decompressor.
`timescale 1ns / 1ps

module yay0_lz_decompressor_tb;
   import yay0lz_pkg::*;

   localparam int PACKET_BYTES  = PACKET_BYTES_DEF;
   localparam int STALL_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 16;
   localparam int MAX_LENGTH    = (1 << PC_W) - 1;
   localparam int SHOWN_ERRORS  = 10;

   typedef struct {
      logic [OUT_TDATA_W-1:0] data;
      logic [COUNT_W-1:0]     count;
      logic                   last;
      logic                   finished;
      logic                   bad;
   } packet_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [IN_TDATA_W-1:0]  req_tdata = '0;
   logic                   req_tuser = FUNC_LITERAL;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [OUT_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic [OUT_TUSER_W-1:0] rsp_tuser;
   logic                   csr_we = 1'b0;
   logic [PC_W-1:0]        csr_wdata = '0;

   // Decoder state as the block should hold it.
   logic [7:0]  history_bytes [WINDOW_BYTES];
   int unsigned produced_bytes = 0;
   int unsigned output_length = 0;
   logic        stream_finished = 1'b0;
   int unsigned packets_predicted = 0;
   packet_type  pending_packets [$];

   int error_count = 0;
   int stall_cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   always #5ns clock = ~clock;

   yay0_lz_decompressor i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
   end

   // Expands one command into the packets it should produce.
   task automatic predict_command(input logic func, input logic [7:0] literal,
                                  input logic [15:0] code, input logic [7:0] ext);
      logic        is_link;
      int unsigned back_dist;
      int unsigned total;
      int unsigned fill;
      logic        bad;
      logic        finished;
      logic [7:0]  b;
      logic [63:0] acc;
      packet_type  pkt;
      is_link   = (func == FUNC_LINK);
      back_dist = 0;
      total     = 1;
      bad       = 1'b0;
      finished  = 1'b0;
      fill      = 0;
      acc       = '0;
      if (stream_finished || produced_bytes >= output_length)
         return;
      if (is_link) begin
         back_dist = code[11:0] + 1;
         total     = (code[15:12] != 0) ? code[15:12] + SHORT_BIAS : ext + LONG_BIAS;
         bad       = back_dist > produced_bytes;
      end
      if (total >= output_length - produced_bytes) begin
         total    = output_length - produced_bytes;
         finished = 1'b1;
      end
      for (int unsigned i = 0; i < total; i++) begin
         if (!is_link)
            b = literal;
         else if (back_dist > produced_bytes)
            b = 8'h00;
         else
            b = history_bytes[WIN_AW'(produced_bytes - back_dist)];
         history_bytes[WIN_AW'(produced_bytes)] = b;
         produced_bytes++;
         acc = acc | (64'(b) << (8 * fill));
         fill++;
         if (fill == PACKET_BYTES || i + 1 == total) begin
            pkt.data     = acc;
            pkt.count    = COUNT_W'(fill);
            pkt.last     = (i + 1 == total);
            pkt.finished = pkt.last && finished;
            pkt.bad      = bad;
            pending_packets.push_back(pkt);
            packets_predicted++;
            acc  = '0;
            fill = 0;
         end
      end
      if (finished)
         stream_finished = 1'b1;
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_cmd(input logic func, input logic [7:0] literal,
                           input logic [15:0] code, input logic [7:0] ext);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {ext, code, literal};
      do
         @(posedge clock);
      while (!req_tready);
      predict_command(func, literal, code, ext);
      @(negedge clock);
   endtask

   // Holds requests back until every predicted packet has left the block.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do
         @(negedge clock);
      while (pending_packets.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_output_length(input int unsigned len);
      csr_we    <= 1'b1;
      csr_wdata <= len[PC_W-1:0];
      @(posedge clock);
      output_length   = len & MAX_LENGTH;
      produced_bytes  = 0;
      stream_finished = 1'b0;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic int unsigned pick_distance();
      int unsigned reach;
      reach = (produced_bytes > WINDOW_BYTES) ? WINDOW_BYTES : produced_bytes;
      if (reach == 0)
         return 1;
      return $urandom_range(reach, 1);
   endfunction

   // With a zero length every request is dropped without output.
   task automatic test_zero_length();
      send_idle_pct = 20;
      recv_idle_pct = 88;
      send_cmd(FUNC_LITERAL, 8'hFF, 16'hFFFF, 8'hFF);
      send_cmd(FUNC_LINK, 8'h00, 16'h1000, 8'h00);
      send_cmd(FUNC_LINK, 8'h12, 16'h0000, 8'hFF);
      wait_for_drain();
      write_output_length(0);
      send_cmd(FUNC_LITERAL, 8'h00, 16'h0000, 8'h00);
      send_cmd(FUNC_LINK, 8'hFF, 16'hFFFF, 8'hFF);
      wait_for_drain();
   endtask

   task automatic test_directed_commands();
      send_idle_pct = 20;
      recv_idle_pct = 88;
      write_output_length(64);
      // A reference before the start of the stream reads zeros.
      send_cmd(FUNC_LINK, 8'h00, 16'h1000, 8'h00);
      send_cmd(FUNC_LITERAL, 8'h00, 16'h0000, 8'h00);
      send_cmd(FUNC_LITERAL, 8'hFF, 16'hFFFF, 8'hFF);
      send_cmd(FUNC_LITERAL, 8'hA5, 16'h5A5A, 8'h3C);
      // Distance one repeats the last byte over the bytes being written.
      send_cmd(FUNC_LINK, 8'h00, 16'h3000, 8'h00);
      send_cmd(FUNC_LINK, 8'h00, 16'hF003, 8'h00);
      send_cmd(FUNC_LINK, 8'h00, 16'h0FFF, 8'h00);
      send_cmd(FUNC_LINK, 8'h00, 16'h2005, 8'h00);
      // The longest copy is cut where the stream ends.
      send_cmd(FUNC_LINK, 8'h00, 16'h0001, 8'hFF);
      send_cmd(FUNC_LITERAL, 8'h5A, 16'h0000, 8'h00);
      send_cmd(FUNC_LINK, 8'h00, 16'h4000, 8'h00);
      wait_for_drain();
      write_output_length(300);
      send_cmd(FUNC_LITERAL, 8'h3C, 16'h0000, 8'h00);
      send_cmd(FUNC_LINK, 8'h00, 16'h0000, 8'hFF);
      send_cmd(FUNC_LINK, 8'h00, 16'hF063, 8'h00);
      // This copy ends exactly on the configured length.
      send_cmd(FUNC_LINK, 8'h00, 16'h7000, 8'h00);
      wait_for_drain();
      write_output_length(1);
      send_cmd(FUNC_LITERAL, 8'h81, 16'h0000, 8'h00);
      send_cmd(FUNC_LITERAL, 8'h7E, 16'h0000, 8'h00);
      wait_for_drain();
   endtask

   // Long copies push the stream past the window size so that reads wrap.
   task automatic test_window_wrap();
      int unsigned r;
      int unsigned back_dist;
      send_idle_pct = 20;
      recv_idle_pct = 88;
      write_output_length($urandom_range(6000, 4500));
      repeat (4) send_cmd(FUNC_LITERAL, 8'($urandom_range(255, 0)),
                          16'($urandom_range(65535, 0)), 8'($urandom_range(255, 0)));
      while (!stream_finished) begin
         r         = $urandom_range(99, 0);
         back_dist = pick_distance();
         if (r < 80)
            send_cmd(FUNC_LINK, 8'($urandom_range(255, 0)), {4'h0, 12'(back_dist - 1)},
                     8'($urandom_range(255, 0)));
         else if (r < 90)
            send_cmd(FUNC_LINK, 8'($urandom_range(255, 0)),
                     {4'($urandom_range(15, 1)), 12'(back_dist - 1)},
                     8'($urandom_range(255, 0)));
         else
            send_cmd(FUNC_LITERAL, 8'($urandom_range(255, 0)),
                     16'($urandom_range(65535, 0)), 8'($urandom_range(255, 0)));
      end
      wait_for_drain();
   endtask

   // Mostly well-formed links with random content, some arbitrary links and
   // literals; the stream is restarted with a new length whenever it ends.
   task automatic test_random_commands(input int count, input int send_pct,
                                       input int recv_pct, input int unsigned first_length);
      int          made;
      int unsigned seen;
      int unsigned r;
      int unsigned back_dist;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      made = 0;
      write_output_length(first_length);
      while (made < count) begin
         if (stream_finished || produced_bytes >= output_length) begin
            if ($urandom_range(3, 0) == 0)
               send_cmd(1'($urandom_range(1, 0)), 8'($urandom_range(255, 0)),
                        16'($urandom_range(65535, 0)), 8'($urandom_range(255, 0)));
            wait_for_drain();
            r = $urandom_range(99, 0);
            if (r < 10)
               write_output_length($urandom_range(8, 1));
            else if (r < 15)
               write_output_length(MAX_LENGTH);
            else
               write_output_length($urandom_range(2500, 100));
         end
         else begin
            seen      = packets_predicted;
            r         = $urandom_range(99, 0);
            back_dist = pick_distance();
            if (r < 35)
               send_cmd(FUNC_LITERAL, 8'($urandom_range(255, 0)),
                        16'($urandom_range(65535, 0)), 8'($urandom_range(255, 0)));
            else if (r < 85)
               send_cmd(FUNC_LINK, 8'($urandom_range(255, 0)),
                        {4'($urandom_range(15, 0)), 12'(back_dist - 1)},
                        8'($urandom_range(255, 0)));
            else
               send_cmd(FUNC_LINK, 8'($urandom_range(255, 0)),
                        16'($urandom_range(65535, 0)), 8'($urandom_range(255, 0)));
            if (packets_predicted != seen)
               made++;
            if ($urandom_range(49, 0) == 0)
               wait_for_drain();
         end
      end
      wait_for_drain();
   endtask

   always @(posedge clock) begin : packet_check
      packet_type want;
      logic       wrong;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_packets.size() == 0) begin
               if (error_count < SHOWN_ERRORS)
                  $display("unexpected packet: data=%h tlast=%b tuser=%b",
                           rsp_tdata, rsp_tlast, rsp_tuser);
               error_count++;
            end
            else begin
               want  = pending_packets.pop_front();
               wrong = (rsp_tdata !== want.data) || (rsp_tuser[3:0] !== want.count) ||
                       (rsp_tlast !== want.last) || (rsp_tuser[4] !== want.finished) ||
                       (rsp_tuser[5] !== want.bad);
               if (wrong) begin
                  if (error_count < SHOWN_ERRORS) begin
                     $display("packet mismatch, expected: data=%h count=%0d end=%b done=%b bad=%b",
                              want.data, want.count, want.last, want.finished, want.bad);
                     $display("                 got:      data=%h count=%0d end=%b done=%b bad=%b",
                              rsp_tdata, rsp_tuser[3:0], rsp_tlast, rsp_tuser[4],
                              rsp_tuser[5]);
                  end
                  error_count++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_zero_length();
      test_directed_commands();
      test_window_wrap();
      test_random_commands(50, 20, 88, $urandom_range(2500, 100));
      test_random_commands(50, 88, 20, $urandom_range(2500, 100));
      test_random_commands(45, 0, 0, MAX_LENGTH);
      wait_for_drain();
      if (error_count == 0 && pending_packets.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/yay0lz_pkg.sv
rtl/yay0lz_ram.sv
rtl/yay0lz_ctrl.sv
rtl/yay0lz_dp.sv
rtl/yay0_lz_decompressor.sv
test/yay0_lz_decompressor_tb.sv
